@@ hw/rtl/dcs_pkg.sv @@
package dcs_pkg;

  localparam int unsigned DefInChannels    = 32;
  localparam int unsigned DefOutChannels   = 32;
  localparam int unsigned DefMaxTaps       = 7;
  localparam int unsigned DefHistoryDepth = 128;

  localparam int unsigned WaddrMaxW = 9;
  localparam int unsigned OcMaxW    = 5;
  localparam int unsigned FillMax   = 255;

  localparam logic [3:0] CFG_KERNEL_TAPS = 4'd0;
  localparam logic [3:0] CFG_DILATION    = 4'd1;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN
  } dcs_state_e;

  typedef struct packed {
    logic               kind;
    logic [4:0]         in_channel;
    logic [2:0]         tap_index;
    logic [4:0]         out_channel_sel;
    logic signed [15:0] value;
  } dcs_in_item_t;

  typedef struct packed {
    logic [4:0]         out_channel;
    logic [19:0]        position;
    logic signed [39:0] sum;
    logic               last;
  } dcs_out_item_t;

  typedef struct packed {
    logic                 vld;
    logic                 first;
    logic [WaddrMaxW-1:0] waddr;
    logic signed [15:0]   x;
  } dcs_tok_t;

  typedef struct packed {
    logic                 we;
    logic [OcMaxW-1:0]    oc;
    logic [WaddrMaxW-1:0] waddr;
    logic signed [15:0]   data;
  } dcs_wr_t;

endpackage

@@ hw/rtl/dcs_cell.sv @@
module dcs_cell import dcs_pkg::*; #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned Depth = DefInChannels * DefMaxTaps,
  parameter int unsigned WaW   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcs_tok_t           tok_i,
  input  dcs_wr_t            wr_i,
  input  logic               shift_i,
  input  logic signed [39:0] sh_acc_i,
  output dcs_tok_t           tok_o,
  output logic signed [39:0] acc_o
);

  logic signed [15:0] mem [Depth];
  logic signed [15:0] w_q;
  dcs_tok_t           tok_q;
  logic signed [31:0] prod_q;
  logic               pv_q, pf_q;
  logic signed [39:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.oc == OcMaxW'(Idx)) begin
      mem[wr_i.waddr[WaW-1:0]] <= wr_i.data;
    end
    w_q    <= mem[tok_i.waddr[WaW-1:0]];
    prod_q <= w_q * tok_q.x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      pv_q  <= 1'b0;
      pf_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      tok_q <= tok_i;
      pv_q  <= tok_q.vld;
      pf_q  <= tok_q.first;
      if (shift_i) begin
        acc_q <= sh_acc_i;
      end else if (pv_q) begin
        acc_q <= pf_q ? 40'(prod_q) : acc_q + 40'(prod_q);
      end
    end
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

@@ hw/rtl/dilated_conv1d_stream.sv @@
// Streaming dilated 1-D convolution. Weight items load per-output-channel weight
// memories inside a row of cells; sample items fill a per-channel ring history.
// When the last input channel of a position arrives and the window is full, the
// sequencer walks every tap and input channel, one step per cycle, and the step
// ripples down the cell row where each cell multiplies and accumulates for its
// own output channel. A closing sample therefore stalls the input while the
// sequencer sets up the window, runs the taps, flushes the cell row and hands
// out OUT_CHANNELS results; other items are taken without a stall. After reset
// the block zeroes the history memory, one word per cycle, before it takes its
// first item.
module dilated_conv1d_stream import dcs_pkg::*; #(
  parameter int unsigned IN_CHANNELS   = DefInChannels,
  parameter int unsigned OUT_CHANNELS  = DefOutChannels,
  parameter int unsigned MAX_TAPS      = DefMaxTaps,
  parameter int unsigned HISTORY_DEPTH = DefHistoryDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dcs_in_item_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dcs_out_item_t out_item_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  localparam int unsigned IcW   = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int unsigned OcW   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int unsigned SlW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned HDep  = IN_CHANNELS * HISTORY_DEPTH;
  localparam int unsigned HaW   = $clog2(HDep);
  localparam int unsigned WDep  = IN_CHANNELS * MAX_TAPS;
  localparam int unsigned WaW   = (WDep > 1) ? $clog2(WDep) : 1;
  localparam int unsigned FlW   = $clog2(OUT_CHANNELS + 5);

  dcs_state_e state_q, state_d;

  logic [2:0]  ktaps_q;
  logic [3:0]  dil_q;
  logic [19:0] pseen_q;
  logic [7:0]  fill_q;
  logic [SlW-1:0] wslot_q, slot_q;
  logic [19:0] pos_q;
  logic [2:0]  taps_q, kcnt_q, scnt_q;
  logic [IcW-1:0] ic_q;
  logic [FlW-1:0] fcnt_q;
  logic [OcW-1:0] ocnt_q;
  logic [HaW-1:0] ccnt_q;

  logic in_acc, out_acc, cfg_acc;
  logic run_step, shift;

  logic signed [15:0] hist [HDep];
  logic signed [15:0] hist_q;
  logic tv_q, tf_q;
  logic [WaW-1:0] twa_q;

  logic [2:0] taps_eff;
  logic [6:0] span;
  logic [7:0] fill_nx;
  logic       is_sample, ic_ok, closes, emit;
  logic       hist_we;
  logic [HaW-1:0] hist_wa, hist_ra;
  logic signed [15:0] hist_wd;
  logic [SlW+1:0] sub1, sub2, add1, add2;
  logic [SlW-1:0] slot_dn, slot_up;

  dcs_wr_t  wr;
  dcs_tok_t tok [OUT_CHANNELS+1];
  logic signed [39:0] acc [OUT_CHANNELS+1];

  // Effective taps, window span and warm-up decision for a closing sample.
  always_comb begin
    taps_eff = (ktaps_q == 3'd0) ? 3'd1 : ktaps_q;
    if (32'(taps_eff) > MAX_TAPS) begin
      taps_eff = 3'(MAX_TAPS);
    end
    span      = 7'(taps_eff - 3'd1) * 7'(dil_q);
    fill_nx   = (fill_q < 8'(FillMax)) ? fill_q + 8'd1 : fill_q;
    is_sample = in_item_i.kind == KIND_SAMPLE;
    ic_ok     = 32'(in_item_i.in_channel) < IN_CHANNELS;
    closes    = is_sample && ic_ok && 32'(in_item_i.in_channel) == IN_CHANNELS - 1;
    emit      = 9'(fill_nx) >= 9'(span) + 9'd1;
  end

  // Ring slot arithmetic modulo the history depth; dilation may exceed it once.
  always_comb begin
    sub1 = (SlW+2)'(slot_q) - (SlW+2)'(dil_q);
    if (sub1[SlW+1]) sub1 = sub1 + (SlW+2)'(HISTORY_DEPTH);
    sub2 = sub1;
    if (sub2[SlW+1]) sub2 = sub2 + (SlW+2)'(HISTORY_DEPTH);
    add1 = (SlW+2)'(slot_q) + (SlW+2)'(dil_q);
    if (add1 >= (SlW+2)'(HISTORY_DEPTH)) add1 = add1 - (SlW+2)'(HISTORY_DEPTH);
    add2 = add1;
    if (add2 >= (SlW+2)'(HISTORY_DEPTH)) add2 = add2 - (SlW+2)'(HISTORY_DEPTH);
    slot_dn = sub2[SlW-1:0];
    slot_up = add2[SlW-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (32'(ccnt_q) == HDep - 1) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc && closes && emit) state_d = ST_SETUP;
      ST_SETUP: if (scnt_q == 3'd0) state_d = ST_RUN;
      ST_RUN: begin
        if (32'(ic_q) == IN_CHANNELS - 1 && kcnt_q == taps_q - 3'd1) state_d = ST_FLUSH;
      end
      ST_FLUSH: if (fcnt_q == '0) state_d = ST_DRAIN;
      ST_DRAIN: if (out_acc && 32'(ocnt_q) == OUT_CHANNELS - 1) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    out_valid_o = state_q == ST_DRAIN;
    cfg_ready_o = !(in_valid_i && state_q == ST_IDLE);
    run_step    = state_q == ST_RUN;
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign shift   = out_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ktaps_q <= 3'd3;
      dil_q   <= 4'd1;
      pseen_q <= '0;
      fill_q  <= '0;
      wslot_q <= '0;
      slot_q  <= '0;
      pos_q   <= '0;
      taps_q  <= 3'd1;
      kcnt_q  <= '0;
      scnt_q  <= '0;
      ic_q    <= '0;
      fcnt_q  <= '0;
      ocnt_q  <= '0;
      ccnt_q  <= '0;
      tv_q    <= 1'b0;
      tf_q    <= 1'b0;
      twa_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) ccnt_q <= ccnt_q + HaW'(1);
      if (cfg_acc && (cfg_index_i == CFG_KERNEL_TAPS || cfg_index_i == CFG_DILATION)) begin
        if (cfg_index_i == CFG_KERNEL_TAPS) ktaps_q <= cfg_data_i[2:0];
        else dil_q <= cfg_data_i[3:0];
        pseen_q <= '0;
        fill_q  <= '0;
      end else if (in_acc && closes) begin
        fill_q  <= fill_nx;
        pseen_q <= pseen_q + 20'd1;
        wslot_q <= (32'(wslot_q) == HISTORY_DEPTH - 1) ? '0 : wslot_q + SlW'(1);
        slot_q  <= wslot_q;
        pos_q   <= pseen_q - 20'(span);
        taps_q  <= taps_eff;
        scnt_q  <= taps_eff - 3'd1;
        kcnt_q  <= '0;
        ic_q    <= '0;
      end
      if (state_q == ST_SETUP && scnt_q != 3'd0) begin
        slot_q <= slot_dn;
        scnt_q <= scnt_q - 3'd1;
      end
      tv_q  <= run_step;
      tf_q  <= run_step && kcnt_q == 3'd0 && ic_q == '0;
      twa_q <= WaW'(32'(ic_q) * MAX_TAPS + 32'(kcnt_q));
      if (run_step) begin
        if (32'(ic_q) == IN_CHANNELS - 1) begin
          ic_q   <= '0;
          kcnt_q <= kcnt_q + 3'd1;
          slot_q <= slot_up;
        end else begin
          ic_q <= ic_q + IcW'(1);
        end
      end
      if (state_q == ST_RUN) fcnt_q <= FlW'(OUT_CHANNELS + 4);
      else if (state_q == ST_FLUSH) fcnt_q <= fcnt_q - FlW'(1);
      if (state_q == ST_FLUSH) ocnt_q <= '0;
      else if (out_acc) ocnt_q <= ocnt_q + OcW'(1);
    end
  end

  always_comb begin
    hist_we = (state_q == ST_CLEAR) || (in_acc && is_sample && ic_ok);
    hist_wa = (state_q == ST_CLEAR) ? ccnt_q
            : HaW'(32'(in_item_i.in_channel) * HISTORY_DEPTH + 32'(wslot_q));
    hist_wd = (state_q == ST_CLEAR) ? 16'sd0 : in_item_i.value;
    hist_ra = HaW'(32'(ic_q) * HISTORY_DEPTH + 32'(slot_q));
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist[hist_wa] <= hist_wd;
    hist_q <= hist[hist_ra];
  end

  always_comb begin
    wr.we    = in_acc && !is_sample && ic_ok && 32'(in_item_i.tap_index) < MAX_TAPS
               && 32'(in_item_i.out_channel_sel) < OUT_CHANNELS;
    wr.oc    = in_item_i.out_channel_sel;
    wr.waddr = WaddrMaxW'(32'(in_item_i.in_channel) * MAX_TAPS + 32'(in_item_i.tap_index));
    wr.data  = in_item_i.value;
    tok[0].vld   = tv_q;
    tok[0].first = tf_q;
    tok[0].waddr = WaddrMaxW'(twa_q);
    tok[0].x     = hist_q;
    acc[OUT_CHANNELS] = '0;
  end

  for (genvar i = 0; i < OUT_CHANNELS; i++) begin : g_cell
    dcs_cell #(
      .Idx   (i),
      .Depth (WDep),
      .WaW   (WaW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[i]),
      .wr_i     (wr),
      .shift_i  (shift),
      .sh_acc_i (acc[i+1]),
      .tok_o    (tok[i+1]),
      .acc_o    (acc[i])
    );
  end

  always_comb begin
    out_item_o.out_channel = 5'(ocnt_q);
    out_item_o.position    = pos_q;
    out_item_o.sum         = acc[0];
    out_item_o.last        = 32'(ocnt_q) == OUT_CHANNELS - 1;
  end

endmodule

@@ verif/dilated_conv1d_stream_tb.sv @@
module dilated_conv1d_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcs_pkg::*;

  localparam int unsigned NumIc = DefInChannels;
  localparam int unsigned NumOc = DefOutChannels;
  localparam int unsigned NumTaps = DefMaxTaps;
  localparam int unsigned Depth = DefHistoryDepth;
  localparam int unsigned CycleLimit = 3000000;

  class conv_scoreboard;
    logic signed [15:0] weights[NumIc][NumTaps][NumOc];
    logic signed [15:0] history[NumIc][Depth];
    logic [19:0] positions_seen;
    int unsigned ring_slot;
    int unsigned fill;
    logic [2:0] taps_reg;
    logic [3:0] dil_reg;
    dcs_out_item_t pending_sums[$];
    int unsigned mismatches;

    function new();
      foreach (weights[i, k, o]) weights[i][k][o] = '0;
      foreach (history[i, s]) history[i][s] = '0;
      positions_seen = '0;
      ring_slot = 0;
      fill = 0;
      taps_reg = 3'd3;
      dil_reg = 4'd1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [7:0] data);
      if (idx == CFG_KERNEL_TAPS) begin
        taps_reg = data[2:0];
      end else if (idx == CFG_DILATION) begin
        dil_reg = data[3:0];
      end else begin
        return;
      end
      positions_seen = '0;
      fill = 0;
    endfunction

    function void note_item(dcs_in_item_t it);
      int unsigned ntaps;
      int unsigned span;
      int unsigned back;
      int unsigned slot;
      longint acc;
      dcs_out_item_t r;
      if (it.kind == KIND_WEIGHT) begin
        if (it.tap_index < NumTaps) begin
          weights[it.in_channel][it.tap_index][it.out_channel_sel] = it.value;
        end
        return;
      end
      history[it.in_channel][ring_slot] = it.value;
      if (it.in_channel != NumIc - 1) return;
      ntaps = (taps_reg == 0) ? 1 : taps_reg;
      if (ntaps > NumTaps) ntaps = NumTaps;
      span = (ntaps - 1) * dil_reg;
      if (fill < FillMax) fill++;
      if (fill >= span + 1) begin
        for (int unsigned o = 0; o < NumOc; o++) begin
          acc = 0;
          for (int unsigned c = 0; c < NumIc; c++) begin
            for (int unsigned k = 0; k < ntaps; k++) begin
              back = (span - k * dil_reg) % Depth;
              slot = (ring_slot + Depth - back) % Depth;
              acc += longint'(weights[c][k][o]) * longint'(history[c][slot]);
            end
          end
          r.out_channel = o[4:0];
          r.position = positions_seen - span[19:0];
          r.sum = acc[39:0];
          r.last = (o == NumOc - 1);
          pending_sums.push_back(r);
        end
      end
      positions_seen = positions_seen + 20'd1;
      ring_slot = (ring_slot + 1) % Depth;
    endfunction

    function void check_sum(dcs_out_item_t got);
      dcs_out_item_t exp_r;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending_sums.pop_front();
      if (got.out_channel !== exp_r.out_channel || got.position !== exp_r.position ||
          got.sum !== exp_r.sum || got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  dcs_in_item_t  in_item_i;
  logic          out_valid_o;
  logic          out_stall_i;
  dcs_out_item_t out_item_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [3:0]    cfg_index_i;
  logic [7:0]    cfg_data_i;

  conv_scoreboard sb = new();
  bit quiet;
  int unsigned out_hold;
  int unsigned cycles;

  dilated_conv1d_stream i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_sum(out_item_o);
        out_hold = quiet ? 0 : $urandom_range(0, 15);
      end
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("dilated_conv1d_stream_tb: errors");
      $finish;
    end
  end

  task automatic send_item(dcs_in_item_t it);
    int unsigned gap;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_positions(int unsigned count);
    dcs_in_item_t it;
    for (int unsigned p = 0; p < count; p++) begin
      for (int unsigned c = 0; c < NumIc; c++) begin
        if ($urandom_range(0, 15) == 0) begin
          it.kind = KIND_WEIGHT;
          it.in_channel = 5'($urandom());
          it.tap_index = 3'($urandom_range(0, 7));
          it.out_channel_sel = 5'($urandom());
          it.value = pick_value();
          send_item(it);
        end
        it.kind = KIND_SAMPLE;
        it.in_channel = c[4:0];
        it.tap_index = 3'($urandom());
        it.out_channel_sel = 5'($urandom());
        it.value = pick_value();
        send_item(it);
      end
    end
  endtask

  initial begin
    dcs_in_item_t it;
    int unsigned taps_list[8];
    int unsigned dil_list[8];
    int unsigned ntaps;
    taps_list = '{1, 7, 2, 0, 7, 3, 5, 6};
    dil_list = '{1, 1, 12, 0, 2, 15, 3, 4};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every weight is written before any sum can read it.
    for (int unsigned c = 0; c < NumIc; c++) begin
      for (int unsigned k = 0; k < NumTaps; k++) begin
        for (int unsigned o = 0; o < NumOc; o++) begin
          it.kind = KIND_WEIGHT;
          it.in_channel = c[4:0];
          it.tap_index = k[2:0];
          it.out_channel_sel = o[4:0];
          it.value = pick_value();
          send_item(it);
        end
      end
    end

    // Reset settings first, then a sweep of tap counts and dilations, then a write to an unused register index.
    quiet = 1'b0;
    run_positions(4);
    for (int unsigned ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(CFG_KERNEL_TAPS, {5'($urandom()), taps_list[ph][2:0]});
      write_reg(CFG_DILATION, {4'($urandom()), dil_list[ph][3:0]});
      quiet = (ph % 3 == 2);
      ntaps = (taps_list[ph] == 0) ? 1 : taps_list[ph];
      run_positions((ntaps - 1) * dil_list[ph] + 1 + $urandom_range(2, 4));
    end
    drain();
    write_reg(4'd5, 8'hff);
    run_positions(2);

    drain();
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("dilated_conv1d_stream_tb: clean");
    end else begin
      $display("dilated_conv1d_stream_tb: errors");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/dcs_pkg.sv
hw/rtl/dcs_cell.sv
hw/rtl/dilated_conv1d_stream.sv
verif/dilated_conv1d_stream_tb.sv
